// ----- hdl/hrt_pkg.sv -----
package hrt_pkg;

  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SP    = 8'd32;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;

  localparam int unsigned MAX_RESULTS = 4;
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam logic [15:0] CODE_MAX    = 16'hFFFF;

  typedef enum logic [2:0] {
    EV_BYTE        = 3'd0,
    EV_STATUS_OK   = 3'd1,
    EV_STATUS_DROP = 3'd2,
    EV_HEADER_OK   = 3'd3,
    EV_HEADER_DROP = 3'd4,
    EV_HEADERS_END = 3'd5,
    EV_MSG_END     = 3'd6
  } event_kind_t;

  typedef enum logic [2:0] {
    TC_VERSION = 3'd0,
    TC_CODE    = 3'd1,
    TC_REASON  = 3'd2,
    TC_KEY     = 3'd3,
    TC_VALUE   = 3'd4,
    TC_BODY    = 3'd5
  } token_class_t;

  typedef enum logic [1:0] {
    PH_STATUS  = 2'd0,
    PH_HEADERS = 2'd1,
    PH_BODY    = 2'd2
  } phase_t;

  typedef struct packed {
    event_kind_t  kind;
    token_class_t cls;
    logic [7:0]   data;
    logic [15:0]  code;
  } res_t;

  typedef struct packed {
    res_t [MAX_RESULTS-1:0] items;
    logic [RES_CNT_W-1:0]   count;
  } bundle_t;

  function automatic res_t mk_event(event_kind_t kind, logic [15:0] code);
    res_t r;
    r.kind = kind;
    r.cls  = TC_VERSION;
    r.data = 8'd0;
    r.code = code;
    return r;
  endfunction

  function automatic res_t mk_byte(token_class_t cls, logic [7:0] data);
    res_t r;
    r.kind = EV_BYTE;
    r.cls  = cls;
    r.data = data;
    r.code = 16'd0;
    return r;
  endfunction

  function automatic bundle_t push(bundle_t bd, res_t r);
    bundle_t b;
    b = bd;
    if (b.count < RES_CNT_W'(MAX_RESULTS)) begin
      b.items[b.count[RES_IDX_W-1:0]] = r;
      b.count = b.count + 1'b1;
    end
    return b;
  endfunction

endpackage

// ----- hdl/hrt_in_if.sv -----
interface hrt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, end_of_message, output ready);
endinterface

// ----- hdl/hrt_out_if.sv -----
interface hrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_kind;
  logic [2:0]  token_class;
  logic [7:0]  out_byte;
  logic [15:0] status_code;
  logic        last_of_run;

  modport source (output valid, event_kind, token_class, out_byte, status_code, last_of_run,
                  input ready);
  modport sink (input valid, event_kind, token_class, out_byte, status_code, last_of_run,
                output ready);
endinterface

// ----- hdl/hrt_front.sv -----
module hrt_front
  import hrt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       valid,
  output logic       ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_message,
  input  logic       queue_full,
  output logic       push_en,
  output bundle_t    push_data
);

  phase_t      phase, phase_next;
  logic [1:0]  status_part, status_part_next;
  logic [15:0] code_acc, code_acc_next;
  logic        digits_ended, digits_ended_next;
  logic        cr_pending, cr_pending_next;
  logic        colon_pending, colon_pending_next;
  logic        in_value, in_value_next;
  logic        line_empty, line_empty_next;

  bundle_t     bd;
  logic        consumed;
  logic        skip;
  logic [19:0] acc_ext;
  logic [19:0] prod;
  logic        accept;

  assign ready     = !queue_full;
  assign accept    = valid && ready;
  assign push_en   = accept && (bd.count != '0);
  assign push_data = bd;

  always_comb begin
    phase_next         = phase;
    status_part_next   = status_part;
    code_acc_next      = code_acc;
    digits_ended_next  = digits_ended;
    cr_pending_next    = cr_pending;
    colon_pending_next = colon_pending;
    in_value_next      = in_value;
    line_empty_next    = line_empty;
    bd                 = '0;
    consumed           = 1'b0;
    skip               = 1'b0;
    acc_ext            = '0;
    prod               = '0;

    // line terminator handling
    if (cr_pending && phase_next != PH_BODY) begin
      if (data_byte == CH_LF) begin
        consumed = 1'b1;
        if (phase_next == PH_STATUS) begin
          bd = push(bd, line_empty ? mk_event(EV_STATUS_DROP, 16'd0)
                                   : mk_event(EV_STATUS_OK, code_acc));
          phase_next = PH_HEADERS;
        end else if (line_empty) begin
          bd = push(bd, mk_event(EV_HEADERS_END, 16'd0));
          phase_next = PH_BODY;
        end else begin
          bd = push(bd, mk_event(in_value ? EV_HEADER_OK : EV_HEADER_DROP, 16'd0));
        end
      end else begin
        if (phase_next == PH_STATUS) begin
          bd = push(bd, mk_event(EV_STATUS_DROP, 16'd0));
          phase_next = PH_HEADERS;
        end else begin
          if (!line_empty) begin
            bd = push(bd, mk_event(EV_HEADER_DROP, 16'd0));
          end
          bd = push(bd, mk_event(EV_HEADERS_END, 16'd0));
          phase_next = PH_BODY;
        end
      end
      status_part_next   = 2'd0;
      code_acc_next      = 16'd0;
      digits_ended_next  = 1'b0;
      colon_pending_next = 1'b0;
      in_value_next      = 1'b0;
      line_empty_next    = 1'b1;
    end
    cr_pending_next = 1'b0;

    // byte classification
    if (!consumed) begin
      if (phase_next == PH_BODY) begin
        bd = push(bd, mk_byte(TC_BODY, data_byte));
      end else if (data_byte == CH_CR) begin
        if (colon_pending_next) begin
          bd = push(bd, mk_byte(TC_KEY, CH_COLON));
        end
        colon_pending_next = 1'b0;
        cr_pending_next    = 1'b1;
      end else begin
        line_empty_next = 1'b0;
        if (phase_next == PH_STATUS) begin
          if (data_byte == CH_SP) begin
            if (status_part_next != 2'd3) begin
              status_part_next = status_part_next + 2'd1;
            end
          end else begin
            case (status_part_next)
              2'd0: begin
                bd = push(bd, mk_byte(TC_VERSION, data_byte));
              end
              2'd1: begin
                if (!digits_ended_next && data_byte >= CH_ZERO && data_byte <= CH_NINE) begin
                  acc_ext = {4'd0, code_acc_next};
                  prod    = (acc_ext << 3) + (acc_ext << 1) + {16'd0, data_byte[3:0]};
                  code_acc_next = (prod > {4'd0, CODE_MAX}) ? CODE_MAX : prod[15:0];
                end else begin
                  digits_ended_next = 1'b1;
                end
                bd = push(bd, mk_byte(TC_CODE, data_byte));
              end
              2'd2: begin
                bd = push(bd, mk_byte(TC_REASON, data_byte));
              end
              default: begin
              end
            endcase
          end
        end else if (in_value_next) begin
          bd = push(bd, mk_byte(TC_VALUE, data_byte));
        end else begin
          if (colon_pending_next) begin
            colon_pending_next = 1'b0;
            if (data_byte == CH_SP) begin
              in_value_next = 1'b1;
              skip          = 1'b1;
            end else begin
              bd = push(bd, mk_byte(TC_KEY, CH_COLON));
            end
          end
          if (!skip) begin
            if (data_byte == CH_COLON) begin
              colon_pending_next = 1'b1;
            end else begin
              bd = push(bd, mk_byte(TC_KEY, data_byte));
            end
          end
        end
      end
    end

    // end of message
    if (end_of_message) begin
      if (phase_next == PH_STATUS) begin
        bd = push(bd, mk_event(EV_STATUS_DROP, 16'd0));
      end else if (phase_next == PH_HEADERS && !line_empty_next) begin
        bd = push(bd, mk_event(EV_HEADER_DROP, 16'd0));
      end
      bd = push(bd, mk_event(EV_MSG_END, 16'd0));
      phase_next         = PH_STATUS;
      status_part_next   = 2'd0;
      code_acc_next      = 16'd0;
      digits_ended_next  = 1'b0;
      cr_pending_next    = 1'b0;
      colon_pending_next = 1'b0;
      in_value_next      = 1'b0;
      line_empty_next    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_STATUS;
      status_part   <= 2'd0;
      code_acc      <= 16'd0;
      digits_ended  <= 1'b0;
      cr_pending    <= 1'b0;
      colon_pending <= 1'b0;
      in_value      <= 1'b0;
      line_empty    <= 1'b1;
    end else if (accept) begin
      phase         <= phase_next;
      status_part   <= status_part_next;
      code_acc      <= code_acc_next;
      digits_ended  <= digits_ended_next;
      cr_pending    <= cr_pending_next;
      colon_pending <= colon_pending_next;
      in_value      <= in_value_next;
      line_empty    <= line_empty_next;
    end
  end

endmodule

// ----- hdl/hrt_queue.sv -----
module hrt_queue
  import hrt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push_en,
  input  bundle_t push_data,
  output logic    full,
  input  logic    pop_en,
  output logic    not_empty,
  output bundle_t head
);

  bundle_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push_en && !full;
  assign do_pop    = pop_en && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- hdl/hrt_back.sv -----
module hrt_back
  import hrt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              not_empty,
  input  bundle_t           head,
  output logic              pop_en,
  hrt_out_if.source         evt
);

  logic [RES_IDX_W-1:0] idx;
  logic                 last;
  res_t                 cur;
  logic                 take;

  assign cur  = head.items[idx];
  assign last = ({1'b0, idx} + 1'b1) == head.count;
  assign take = not_empty && evt.ready;

  assign evt.valid       = not_empty;
  assign evt.event_kind  = cur.kind;
  assign evt.token_class = cur.cls;
  assign evt.out_byte    = cur.data;
  assign evt.status_code = cur.code;
  assign evt.last_of_run = last;
  assign pop_en          = take && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (take) begin
      idx <= last ? '0 : idx + 1'b1;
    end
  end

endmodule

// ----- hdl/http_response_header_tokenizer_top.sv -----
// HTTP response tokenizer: takes one response byte per request on msg and returns
// tagged bytes and line events on evt, one result per cycle while evt is ready. A
// byte is taken every cycle as long as each byte yields at most one result and evt
// is ready; a byte that yields several (up to four, e.g. a line end plus end of
// message) sends them in turn on the result port. Results of each byte are grouped
// in a two-entry queue between the classifier and the output serializer, so input
// keeps flowing while a result waits. No initialization pass after reset.
module http_response_header_tokenizer_top
  import hrt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  hrt_in_if.sink    msg,
  hrt_out_if.source evt
);

  logic    queue_full;
  logic    push_en;
  bundle_t push_data;
  logic    pop_en;
  logic    not_empty;
  bundle_t head;

  hrt_front u_front (
    .clk            (clk),
    .rst            (rst),
    .valid          (msg.valid),
    .ready          (msg.ready),
    .data_byte      (msg.data_byte),
    .end_of_message (msg.end_of_message),
    .queue_full     (queue_full),
    .push_en        (push_en),
    .push_data      (push_data)
  );

  hrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (push_en),
    .push_data (push_data),
    .full      (queue_full),
    .pop_en    (pop_en),
    .not_empty (not_empty),
    .head      (head)
  );

  hrt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop_en    (pop_en),
    .evt       (evt)
  );

endmodule

// ----- hdl/hrt_checker.sv -----
module hrt_checker
  import hrt_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        evt_valid,
  input logic        evt_ready,
  input logic [2:0]  evt_event_kind,
  input logic [2:0]  evt_token_class,
  input logic [7:0]  evt_out_byte,
  input logic [15:0] evt_status_code,
  input logic        evt_last_of_run
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    evt_valid && !evt_ready |=> evt_valid && $stable(evt_event_kind) &&
      $stable(evt_token_class) && $stable(evt_out_byte) && $stable(evt_status_code) &&
      $stable(evt_last_of_run))
    else $error("result changed while stalled");

  a_code_only_status: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_event_kind != EV_STATUS_OK |-> evt_status_code == 16'd0)
    else $error("status code outside status ok");

  a_byte_fields: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_event_kind != EV_BYTE |-> evt_out_byte == 8'd0 &&
      evt_token_class == 3'd0)
    else $error("byte fields set on line event");

  a_msg_end_last: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_event_kind == EV_MSG_END |-> evt_last_of_run)
    else $error("message end not last of run");

endmodule

bind http_response_header_tokenizer_top hrt_checker u_hrt_checker (
  .clk             (clk),
  .rst             (rst),
  .evt_valid       (evt.valid),
  .evt_ready       (evt.ready),
  .evt_event_kind  (evt.event_kind),
  .evt_token_class (evt.token_class),
  .evt_out_byte    (evt.out_byte),
  .evt_status_code (evt.status_code),
  .evt_last_of_run (evt.last_of_run)
);
